/* rtl/mirror_edge_blend_rgb_defines.svh */
// ----------------------------------------------------------------------------
// Mirror edge blend defines
// Assertion helpers used by the top file of the block.
// ----------------------------------------------------------------------------
`ifndef MIRROR_EDGE_BLEND_RGB_DEFINES_SVH
`define MIRROR_EDGE_BLEND_RGB_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MEB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mirror_edge_blend_rgb: check failed");

// next-cycle implication, sampled on clk, off during reset
`define MEB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mirror_edge_blend_rgb: check failed");

`endif

/* rtl/meb_pkg.sv */
// ----------------------------------------------------------------------------
// Mirror edge blend package
// Widths, constants and shared types of the edge blend block.
// ----------------------------------------------------------------------------
package meb_pkg;

	localparam int PIX_W     = 8;
	localparam int DIST_W    = 14;
	localparam int BAND_W    = 14;
	localparam int STEP_W    = 16;
	localparam int PCT_W     = 7;
	localparam int CNT_PIX_W = 16;
	localparam int SIZE_W    = 15;
	localparam int CFG_DW    = 16;
	localparam int CFG_IW    = 3;
	localparam int WGT_W     = 17;
	localparam int PROD_W    = PIX_W + WGT_W;
	localparam int DIV_NUM_W = 22;
	localparam int DIV_DEN_W = 15;

	// percent band: (pct*size)/200 as ((pct*size) >> 3) * ceil(2^24/25) >> 24,
	// exact for every product below 2^22
	localparam int PCT_PROD_W    = PCT_W + SIZE_W;
	localparam int BAND_PRE_SH   = 3;
	localparam int RECIP_W       = 20;
	localparam int RECIP_PROD_W  = PCT_PROD_W - BAND_PRE_SH + RECIP_W;
	localparam int BAND_RECIP_SH = 24;
	localparam logic [RECIP_W-1:0] BAND_RECIP = 20'd671089;

	localparam int BAND_DIV = 200;
	localparam logic [WGT_W-1:0]     WEIGHT_HALF = 17'h08000;
	localparam logic [WGT_W-1:0]     WEIGHT_ONE  = 17'h10000;
	localparam logic [DIV_NUM_W-1:0] STEP_NUM    = 22'h010000;

	typedef logic [2:0][PIX_W-1:0] rgb_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_USE_PIX  = 3'd0,
		REG_X_PCT    = 3'd1,
		REG_Y_PCT    = 3'd2,
		REG_X_PIX    = 3'd3,
		REG_Y_PIX    = 3'd4,
		REG_WIDTH    = 3'd5,
		REG_HEIGHT   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                 use_pixel_counts;
		logic [PCT_W-1:0]     x_percent;
		logic [PCT_W-1:0]     y_percent;
		logic [CNT_PIX_W-1:0] x_pixels;
		logic [CNT_PIX_W-1:0] y_pixels;
		logic [SIZE_W-1:0]    image_width;
		logic [SIZE_W-1:0]    image_height;
	} cfg_t;

	typedef struct packed {
		logic [BAND_W-1:0] band_x;
		logic [STEP_W-1:0] step_x;
		logic [BAND_W-1:0] band_y;
		logic [STEP_W-1:0] step_y;
	} cal_t;

	typedef enum logic [2:0] {
		CAL_IDLE,
		CAL_BAND_GO,
		CAL_BAND_WAIT,
		CAL_STEP_GO,
		CAL_STEP_WAIT
	} cal_state_t;

endpackage

/* rtl/mirror_edge_blend_rgb.sv */
// Each accepted pair passes four register stages before out_valid rises.
// Throughput: one pair per cycle while calibration is idle; a waiting output item
// holds the whole pipeline. After the last config write, in_ready stays low until
// calibration ends: per axis the band first, then a serial divide for the weight step.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register
// defaults: percent mode, zero bands, image size 1 by 1, so every pair passes.
// ----------------------------------------------------------------------------
// Mirror edge blend, RGB
// Blends mirrored pixel pairs near opposite image edges for seamless tiling.
// ----------------------------------------------------------------------------
`include "mirror_edge_blend_rgb_defines.svh"

module mirror_edge_blend_rgb (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write_en,
	input  logic [meb_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [meb_pkg::CFG_DW-1:0]    cfg_data,
	// input item: one mirrored pixel pair
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          axis,
	input  logic [meb_pkg::DIST_W-1:0]    edge_distance,
	input  logic [meb_pkg::PIX_W-1:0]     near_red,
	input  logic [meb_pkg::PIX_W-1:0]     near_green,
	input  logic [meb_pkg::PIX_W-1:0]     near_blue,
	input  logic [meb_pkg::PIX_W-1:0]     far_red,
	input  logic [meb_pkg::PIX_W-1:0]     far_green,
	input  logic [meb_pkg::PIX_W-1:0]     far_blue,
	// result item: blended pair
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [meb_pkg::PIX_W-1:0]     out_near_red,
	output logic [meb_pkg::PIX_W-1:0]     out_near_green,
	output logic [meb_pkg::PIX_W-1:0]     out_near_blue,
	output logic [meb_pkg::PIX_W-1:0]     out_far_red,
	output logic [meb_pkg::PIX_W-1:0]     out_far_green,
	output logic [meb_pkg::PIX_W-1:0]     out_far_blue,
	output logic                          in_band
);
	import meb_pkg::*;

	cfg_t cfg_q;
	cal_t cal_w;
	logic cal_idle;
	logic pipe_en;
	logic in_fire;
	rgb_t near_px, far_px;
	rgb_t out_near, out_far;

	// Config registers. Index 7 is unused and ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_pixel_counts <= 1'b0;
			cfg_q.x_percent        <= '0;
			cfg_q.y_percent        <= '0;
			cfg_q.x_pixels         <= '0;
			cfg_q.y_pixels         <= '0;
			cfg_q.image_width      <= SIZE_W'(1);
			cfg_q.image_height     <= SIZE_W'(1);
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_USE_PIX: cfg_q.use_pixel_counts <= cfg_data[0];
				REG_X_PCT:   cfg_q.x_percent        <= cfg_data[PCT_W-1:0];
				REG_Y_PCT:   cfg_q.y_percent        <= cfg_data[PCT_W-1:0];
				REG_X_PIX:   cfg_q.x_pixels         <= cfg_data;
				REG_Y_PIX:   cfg_q.y_pixels         <= cfg_data;
				REG_WIDTH:   cfg_q.image_width      <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:  cfg_q.image_height     <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Band = clip(pixels or percent*size/200, size/2); step = 0x10000/(2*band+1).
	// Both live in registers so the datapath only selects them per axis.
	meb_cal u_cal (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write_en),
		.cfg      (cfg_q),
		.cal      (cal_w),
		.idle     (cal_idle)
	);

	// Whole pipeline advances together; it holds while the output item waits.
	assign pipe_en  = !out_valid || out_ready;
	assign in_ready = pipe_en && cal_idle;
	assign in_fire  = in_valid && in_ready;

	assign near_px = {near_blue, near_green, near_red};
	assign far_px  = {far_blue, far_green, far_red};

	meb_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (pipe_en),
		.in_fire    (in_fire),
		.axis       (axis),
		.edge_dist  (edge_distance),
		.near_px    (near_px),
		.far_px     (far_px),
		.cal        (cal_w),
		.out_valid  (out_valid),
		.out_near   (out_near),
		.out_far    (out_far),
		.out_in_band(in_band)
	);

	assign out_near_red   = out_near[0];
	assign out_near_green = out_near[1];
	assign out_near_blue  = out_near[2];
	assign out_far_red    = out_far[0];
	assign out_far_green  = out_far[1];
	assign out_far_blue   = out_far[2];

	// divider check terms: step*(2*band+1) must bracket 0x10000
	logic [31:0] den_x, den_y, sp_x, sp_y;
	logic        clip_ok, step_x_ok, step_y_ok;
	assign den_x = 32'({cal_w.band_x, 1'b1});
	assign den_y = 32'({cal_w.band_y, 1'b1});
	assign sp_x  = 32'(cal_w.step_x) * den_x;
	assign sp_y  = 32'(cal_w.step_y) * den_y;

	assign clip_ok   = (cal_w.band_x <= cfg_q.image_width[SIZE_W-1:1])
		&& (cal_w.band_y <= cfg_q.image_height[SIZE_W-1:1]);
	assign step_x_ok = (sp_x <= 32'h10000) && (sp_x + den_x > 32'h10000);
	assign step_y_ok = (sp_y <= 32'h10000) && (sp_y + den_y > 32'h10000);

	`MEB_ASSERT_NXT(a_cfg_blocks_input, cfg_write_en, !in_ready)
	`MEB_ASSERT_IMP(a_band_clip, cal_idle, clip_ok)
	`MEB_ASSERT_IMP(a_step_x, cal_idle && (cal_w.band_x != '0), step_x_ok)
	`MEB_ASSERT_IMP(a_step_y, cal_idle && (cal_w.band_y != '0), step_y_ok)

endmodule

/* rtl/meb_div.sv */
// ----------------------------------------------------------------------------
// Mirror edge blend divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module meb_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [meb_pkg::DIV_NUM_W-1:0]  num,
	input  logic [meb_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [meb_pkg::DIV_NUM_W-1:0]  quot
);
	import meb_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 take;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator register shifts out dividend bits, shifts in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], take};
			rem_q <= take ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

/* rtl/meb_cal.sv */
// ----------------------------------------------------------------------------
// Mirror edge blend calibration
// Recomputes band widths and weight steps of both axes after config writes.
// ----------------------------------------------------------------------------
module meb_cal (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  meb_pkg::cfg_t cfg,
	output meb_pkg::cal_t cal,
	output logic          idle
);
	import meb_pkg::*;

	cal_state_t state_q, state_d;
	logic       axis_q;
	logic       dirty_q;

	logic [BAND_W-1:0] band_x_q, band_y_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;

	logic [PCT_W-1:0]                  pct;
	logic [CNT_PIX_W-1:0]              pix;
	logic [SIZE_W-1:0]                 size;
	logic [BAND_W-1:0]                 half;
	logic [BAND_W-1:0]                 band_cur;
	logic [BAND_W-1:0]                 band_clip;
	logic [PCT_PROD_W-1:0]             pct_prod_q;
	logic [PCT_PROD_W-BAND_PRE_SH-1:0] pct_eighth;
	logic [RECIP_PROD_W-1:0]           recip_prod;
	logic [CNT_PIX_W-1:0]              band_raw;
	logic                              band_we;
	logic                              step_we;

	meb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		pct        = axis_q ? cfg.y_percent : cfg.x_percent;
		pix        = axis_q ? cfg.y_pixels : cfg.x_pixels;
		size       = axis_q ? cfg.image_height : cfg.image_width;
		half       = size[SIZE_W-1:1];
		band_cur   = axis_q ? band_y_q : band_x_q;
		// divide by 200 as a shift by 3 and a reciprocal multiply for 25
		pct_eighth = pct_prod_q[PCT_PROD_W-1:BAND_PRE_SH];
		recip_prod = RECIP_PROD_W'(pct_eighth) * RECIP_PROD_W'(BAND_RECIP);
		band_raw   = cfg.use_pixel_counts ? pix
			: CNT_PIX_W'(recip_prod >> BAND_RECIP_SH);
		band_clip  = (band_raw > CNT_PIX_W'(half)) ? half : band_raw[BAND_W-1:0];
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = STEP_NUM;
		div_den   = {band_cur, 1'b1};
		band_we   = 1'b0;
		step_we   = 1'b0;
		case (state_q)
			CAL_IDLE: begin
				if (dirty_q) begin
					state_d = CAL_BAND_GO;
				end
			end
			CAL_BAND_GO: begin
				// percent times size is registered here
				state_d = CAL_BAND_WAIT;
			end
			CAL_BAND_WAIT: begin
				band_we = 1'b1;
				state_d = CAL_STEP_GO;
			end
			CAL_STEP_GO: begin
				div_start = 1'b1;
				state_d   = CAL_STEP_WAIT;
			end
			CAL_STEP_WAIT: begin
				if (div_done) begin
					step_we = 1'b1;
					state_d = axis_q ? CAL_IDLE : CAL_BAND_GO;
				end
			end
			default: state_d = CAL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CAL_IDLE;
			axis_q     <= 1'b0;
			dirty_q    <= 1'b0;
			band_x_q   <= '0;
			band_y_q   <= '0;
			step_x_q   <= '0;
			step_y_q   <= '0;
			pct_prod_q <= '0;
		end else begin
			state_q <= state_d;
			// a write during a pass forces another full pass
			if (cfg_write) begin
				dirty_q <= 1'b1;
			end else if (state_q == CAL_IDLE && dirty_q) begin
				dirty_q <= 1'b0;
			end
			if (state_q == CAL_IDLE) begin
				axis_q <= 1'b0;
			end else if (step_we) begin
				axis_q <= 1'b1;
			end
			if (state_q == CAL_BAND_GO) begin
				pct_prod_q <= PCT_PROD_W'(pct) * PCT_PROD_W'(size);
			end
			if (band_we && !axis_q) band_x_q <= band_clip;
			if (band_we && axis_q)  band_y_q <= band_clip;
			if (step_we && !axis_q) step_x_q <= div_quot[STEP_W-1:0];
			if (step_we && axis_q)  step_y_q <= div_quot[STEP_W-1:0];
		end
	end

	assign cal.band_x = band_x_q;
	assign cal.step_x = step_x_q;
	assign cal.band_y = band_y_q;
	assign cal.step_y = step_y_q;
	assign idle       = (state_q == CAL_IDLE) && !dirty_q;

endmodule

/* rtl/meb_blend.sv */
// ----------------------------------------------------------------------------
// Mirror edge blend datapath
// Four-stage weight and mix pipeline, one mirrored pixel pair per cycle while en is high.
// ----------------------------------------------------------------------------
module meb_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_fire,
	input  logic                         axis,
	input  logic [meb_pkg::DIST_W-1:0]   edge_dist,
	input  meb_pkg::rgb_t                near_px,
	input  meb_pkg::rgb_t                far_px,
	input  meb_pkg::cal_t                cal,
	output logic                         out_valid,
	output meb_pkg::rgb_t                out_near,
	output meb_pkg::rgb_t                out_far,
	output logic                         out_in_band
);
	import meb_pkg::*;

	localparam int DPROD_W = DIST_W + STEP_W;

	logic [BAND_W-1:0] band_sel;
	logic [STEP_W-1:0] step_sel;

	// stage 1: band test, distance times step
	logic               v_s1, in_band_s1;
	logic [DPROD_W-1:0] dprod_s1;
	logic [STEP_W-2:0]  half_step_s1;
	rgb_t               near_s1, far_s1;

	// stage 2: weight and complement
	logic             v_s2, in_band_s2;
	logic [WGT_W-1:0] wa_s2, wb_s2;
	rgb_t             near_s2, far_s2;

	// stage 3: channel products
	logic                   v_s3, in_band_s3;
	logic [2:0][PROD_W-1:0] nwa_s3, fwb_s3, nwb_s3, fwa_s3;
	rgb_t                   near_s3, far_s3;

	// stage 4: output register
	logic v_s4, in_band_s4;
	rgb_t near_s4, far_s4;

	logic [WGT_W-1:0] wa_d;

	assign band_sel = axis ? cal.band_y : cal.band_x;
	assign step_sel = axis ? cal.step_y : cal.step_x;
	// inside the band the weight never passes 0x10000, so 17 bits hold it
	assign wa_d = WEIGHT_HALF + WGT_W'(half_step_s1) + dprod_s1[WGT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_band_s1   <= edge_dist < band_sel;
			dprod_s1     <= DPROD_W'(edge_dist) * DPROD_W'(step_sel);
			half_step_s1 <= step_sel[STEP_W-1:1];
			near_s1      <= near_px;
			far_s1       <= far_px;

			in_band_s2 <= in_band_s1;
			wa_s2      <= wa_d;
			wb_s2      <= WEIGHT_ONE - wa_d;
			near_s2    <= near_s1;
			far_s2     <= far_s1;

			in_band_s3 <= in_band_s2;
			near_s3    <= near_s2;
			far_s3     <= far_s2;
			for (int c = 0; c < 3; c++) begin
				nwa_s3[c] <= PROD_W'(near_s2[c]) * PROD_W'(wa_s2);
				fwb_s3[c] <= PROD_W'(far_s2[c]) * PROD_W'(wb_s2);
				nwb_s3[c] <= PROD_W'(near_s2[c]) * PROD_W'(wb_s2);
				fwa_s3[c] <= PROD_W'(far_s2[c]) * PROD_W'(wa_s2);
			end

			in_band_s4 <= in_band_s3;
			for (int c = 0; c < 3; c++) begin
				if (in_band_s3) begin
					near_s4[c] <= PIX_W'((nwa_s3[c] + fwb_s3[c]) >> 16);
					far_s4[c]  <= PIX_W'((nwb_s3[c] + fwa_s3[c]) >> 16);
				end else begin
					near_s4[c] <= near_s3[c];
					far_s4[c]  <= far_s3[c];
				end
			end
		end
	end

	assign out_valid   = v_s4;
	assign out_near    = near_s4;
	assign out_far     = far_s4;
	assign out_in_band = in_band_s4;

endmodule

/* bench/tb_mirror_edge_blend_rgb.sv */
// ----------------------------------------------------------------------------
// Mirror edge blend testbench
// Streams mirrored pixel pairs through the blender under several band setups
// and checks every blended pair against a behavioral model of the band,
// step and weight arithmetic kept inside this bench.
// ----------------------------------------------------------------------------
module tb_mirror_edge_blend_rgb;
	import meb_pkg::*;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int DRAIN_CYCLES     = 8;        // margin past the pipeline depth to catch stray results
	localparam int DIST_MAX         = (1 << DIST_W) - 1;
	localparam int SETUPS_PER_PHASE = 10;
	localparam int PAIRS_PER_SETUP  = 64;
	localparam int NO_POKE          = -1;
	// index 7 maps to no register; writes there must be dropped
	localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;

	// one input item: a mirrored pixel pair; channel 0 red, 1 green, 2 blue
	typedef struct packed {
		logic              axis;
		logic [DIST_W-1:0] edge_dist;
		rgb_t              near_px;
		rgb_t              far_px;
	} pair_t;

	// one result item
	typedef struct packed {
		rgb_t near_px;
		rgb_t far_px;
		logic in_band;
	} blend_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_write_en   = 1'b0;
	logic [CFG_IW-1:0]    cfg_index      = '0;
	logic [CFG_DW-1:0]    cfg_data       = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic                 axis           = 1'b0;
	logic [DIST_W-1:0]    edge_distance  = '0;
	logic [PIX_W-1:0]     near_red       = '0;
	logic [PIX_W-1:0]     near_green     = '0;
	logic [PIX_W-1:0]     near_blue      = '0;
	logic [PIX_W-1:0]     far_red        = '0;
	logic [PIX_W-1:0]     far_green      = '0;
	logic [PIX_W-1:0]     far_blue       = '0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [PIX_W-1:0]     out_near_red;
	logic [PIX_W-1:0]     out_near_green;
	logic [PIX_W-1:0]     out_near_blue;
	logic [PIX_W-1:0]     out_far_red;
	logic [PIX_W-1:0]     out_far_green;
	logic [PIX_W-1:0]     out_far_blue;
	logic                 in_band;

	cfg_t        regs_shadow;          // bench copy of the register file
	blend_t      blend_expected [$];   // blended pairs still owed by the block
	int          mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int          send_idle_pct  = 0;   // chance per cycle the sender holds off
	int          recv_idle_pct  = 0;   // chance per cycle the receiver stalls
	string       chan_name [3]  = '{"red", "green", "blue"};

	mirror_edge_blend_rgb dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.axis           (axis),
		.edge_distance  (edge_distance),
		.near_red       (near_red),
		.near_green     (near_green),
		.near_blue      (near_blue),
		.far_red        (far_red),
		.far_green      (far_green),
		.far_blue       (far_blue),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_near_red   (out_near_red),
		.out_near_green (out_near_green),
		.out_near_blue  (out_near_blue),
		.out_far_red    (out_far_red),
		.out_far_green  (out_far_green),
		.out_far_blue   (out_far_blue),
		.in_band        (in_band)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Behavioral model
	// ------------------------------------------------------------------------

	// band of one axis: from pixel count or percent of size, clipped to size/2
	function automatic int unsigned axis_band(input logic ax);
		int unsigned pct, pix, size, band;
		if (ax == 1'b0) begin
			pct  = regs_shadow.x_percent;
			pix  = regs_shadow.x_pixels;
			size = regs_shadow.image_width;
		end else begin
			pct  = regs_shadow.y_percent;
			pix  = regs_shadow.y_pixels;
			size = regs_shadow.image_height;
		end
		band = regs_shadow.use_pixel_counts ? pix : (pct * size) / BAND_DIV;
		if (band > size / 2)
			band = size / 2;
		return band;
	endfunction

	// weighted mix of the pair; the partner gets the complement weight
	function automatic blend_t blend_pair(input pair_t p);
		int unsigned band, stp, wa, wb;
		blend_t r;
		band      = axis_band(p.axis);
		r.near_px = p.near_px;
		r.far_px  = p.far_px;
		r.in_band = 1'b0;
		if (p.edge_dist < band) begin
			stp = int'(WEIGHT_ONE) / (2 * band + 1);
			wa  = int'(WEIGHT_HALF) + stp / 2 + p.edge_dist * stp;
			wb  = int'(WEIGHT_ONE) - wa;
			for (int c = 0; c < 3; c++) begin
				r.near_px[c] = PIX_W'((p.near_px[c] * wa + p.far_px[c] * wb) >> 16);
				r.far_px[c]  = PIX_W'((p.near_px[c] * wb + p.far_px[c] * wa) >> 16);
			end
			r.in_band = 1'b1;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------------

	// present one pair, hold it until taken, then log what it must become
	task automatic send_pair(input pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		axis          <= p.axis;
		edge_distance <= p.edge_dist;
		near_red      <= p.near_px[0];
		near_green    <= p.near_px[1];
		near_blue     <= p.near_px[2];
		far_red       <= p.far_px[0];
		far_green     <= p.far_px[1];
		far_blue      <= p.far_px[2];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		blend_expected.push_back(blend_pair(p));
	endtask

	function automatic pair_t pixel_pair(input logic ax, input int d, input rgb_t n,
		input rgb_t f);
		pair_t p;
		p.axis      = ax;
		p.edge_dist = DIST_W'(d);
		p.near_px   = n;
		p.far_px    = f;
		return p;
	endfunction

	// stop sending and wait for every owed result; the block is idle after
	task automatic drain_results();
		in_valid <= 1'b0;
		while (blend_expected.size() != 0)
			@(posedge clk);
	endtask

	// one register write; write enable is left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input int value);
		logic [CFG_DW-1:0] data;
		data = CFG_DW'(value);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(posedge clk);
		case (idx)
			REG_USE_PIX: regs_shadow.use_pixel_counts = data[0];
			REG_X_PCT:   regs_shadow.x_percent        = data[PCT_W-1:0];
			REG_Y_PCT:   regs_shadow.y_percent        = data[PCT_W-1:0];
			REG_X_PIX:   regs_shadow.x_pixels         = data[CNT_PIX_W-1:0];
			REG_Y_PIX:   regs_shadow.y_pixels         = data[CNT_PIX_W-1:0];
			REG_WIDTH:   regs_shadow.image_width      = data[SIZE_W-1:0];
			REG_HEIGHT:  regs_shadow.image_height     = data[SIZE_W-1:0];
			default:     ;
		endcase
	endtask

	// full register load while idle; optional write to the unmapped index last,
	// so a decoder that aliases it onto a real register would be caught
	task automatic program_regs(input int use_pix, input int x_pct, input int y_pct,
		input int x_pix, input int y_pix, input int wid, input int hgt,
		input int unused_data);
		drain_results();
		write_reg(REG_USE_PIX, use_pix);
		write_reg(REG_X_PCT, x_pct);
		write_reg(REG_Y_PCT, y_pct);
		write_reg(REG_X_PIX, x_pix);
		write_reg(REG_Y_PIX, y_pix);
		write_reg(REG_WIDTH, wid);
		write_reg(REG_HEIGHT, hgt);
		if (unused_data != NO_POKE)
			write_reg(REG_UNUSED, unused_data);
		cfg_write_en <= 1'b0;
	endtask

	// random register values, extremes weighted in, junk above the field width for sizes and percents
	function automatic int pick_size();
		int v;
		case ($urandom_range(9))
			0:       v = 0;
			1:       v = 1;
			2:       v = 32767;
			3, 4, 5: v = $urandom_range(64, 2);
			default: v = $urandom_range(32767, 1);
		endcase
		return v | ($urandom_range(1) << SIZE_W);
	endfunction

	function automatic int pick_percent();
		int v;
		case ($urandom_range(7))
			0:       v = 0;
			1:       v = 100;
			2:       v = 127;
			default: v = $urandom_range(127);
		endcase
		return v | ($urandom_range(511) << PCT_W);
	endfunction

	function automatic int pick_pixels();
		case ($urandom_range(9))
			0:       return 0;
			1:       return 32768;
			2:       return 65535;
			3, 4, 5: return $urandom_range(64);
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each accepted result with the oldest owed one
	always @(posedge clk) begin
		blend_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got.near_px = {out_near_blue, out_near_green, out_near_red};
			got.far_px  = {out_far_blue, out_far_green, out_far_red};
			got.in_band = in_band;
			if (blend_expected.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = blend_expected.pop_front();
				for (int c = 0; c < 3; c++) begin
					if (got.near_px[c] !== want.near_px[c])
						report_mismatch($sformatf("out_near_%s got %0h expected %0h",
							chan_name[c], got.near_px[c], want.near_px[c]));
					if (got.far_px[c] !== want.far_px[c])
						report_mismatch($sformatf("out_far_%s got %0h expected %0h",
							chan_name[c], got.far_px[c], want.far_px[c]));
				end
				if (got.in_band !== want.in_band)
					report_mismatch($sformatf("in_band got %0h expected %0h",
						got.in_band, want.in_band));
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[mirror_edge_blend_rgb] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// reset state: size 1 by 1 gives zero bands, pairs pass untouched
	task automatic test_reset_passthrough();
		send_pair(pixel_pair(1'b0, 0, 24'hFFFFFF, 24'h000000));
		send_pair(pixel_pair(1'b1, 0, 24'h000000, 24'hFFFFFF));
	endtask

	// widest band on x, narrow band on y; first, last and first-outside distances
	task automatic test_band_edges();
		program_regs(1, 0, 0, 16383, 3, 32767, 7, NO_POKE);
		send_pair(pixel_pair(1'b0, 0, 24'hFFFFFF, 24'h000000));
		send_pair(pixel_pair(1'b0, 16382, 24'h000000, 24'hFFFFFF));
		send_pair(pixel_pair(1'b0, 16383, 24'hFF00FF, 24'h00FF00));
		send_pair(pixel_pair(1'b1, 0, 24'hFF00FF, 24'h00FF00));
		send_pair(pixel_pair(1'b1, 1, 24'h00FF00, 24'hFF00FF));
		send_pair(pixel_pair(1'b1, 2, 24'hFFFFFF, 24'h000000));
		send_pair(pixel_pair(1'b1, 3, 24'h123456, 24'hABCDEF));
		send_pair(pixel_pair(1'b1, DIST_MAX, 24'hFFFFFF, 24'hFFFFFF));
		// percent mode at full size, 100 percent on both axes
		program_regs(0, 100, 100, 0, 0, 32767, 32767, NO_POKE);
		send_pair(pixel_pair(1'b1, 16382, 24'h00FF00, 24'hFF00FF));
		send_pair(pixel_pair(1'b0, 8000, 24'h808080, 24'h7F7F7F));
	endtask

	// zero size clips any band to nothing; tiny size rounds percent to zero
	task automatic test_zero_band();
		program_regs(1, 0, 0, 65535, 65535, 0, 0, NO_POKE);
		send_pair(pixel_pair(1'b0, 0, 24'hFFFFFF, 24'h000000));
		send_pair(pixel_pair(1'b1, 0, 24'h000000, 24'hFFFFFF));
		program_regs(0, 100, 100, 0, 0, 1, 1, NO_POKE);
		send_pair(pixel_pair(1'b0, 0, 24'hA5A5A5, 24'h5A5A5A));
	endtask

	// percent above 100, pixel counts beyond size, write to the unmapped index
	task automatic test_register_limits();
		program_regs(0, 127, 127, 0, 0, 32767, 32767, 2);
		send_pair(pixel_pair(1'b0, 16382, 24'hFF0000, 24'h0000FF));
		send_pair(pixel_pair(1'b1, 0, 24'h0000FF, 24'hFF0000));
		// x band 50, y band 4; y collapses if index 7 lands on the height
		program_regs(1, 0, 0, 32768, 65535, 100, 9, 2);
		send_pair(pixel_pair(1'b0, 49, 24'hFFFFFF, 24'h000000));
		send_pair(pixel_pair(1'b0, 50, 24'hFFFFFF, 24'h000000));
		send_pair(pixel_pair(1'b1, 3, 24'h000000, 24'hFFFFFF));
	endtask

	// random setups and pairs in three phases; the last runs without idling
	task automatic test_random_traffic();
		pair_t       p;
		int unsigned band, sel, d;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < SETUPS_PER_PHASE; s++) begin
				program_regs($urandom_range(16'hFFFF), pick_percent(), pick_percent(),
					pick_pixels(), pick_pixels(), pick_size(), pick_size(),
					($urandom_range(3) == 0) ? int'($urandom_range(16'hFFFF)) : NO_POKE);
				for (int k = 0; k < PAIRS_PER_SETUP; k++) begin
					p.axis = $urandom_range(1);
					band   = axis_band(p.axis);
					sel    = $urandom_range(99);
					// mostly inside the band, some right at its end, rest anywhere
					if (band != 0 && sel < 70) begin
						d = $urandom_range(band - 1);
					end else if (band != 0 && sel < 85) begin
						d = band + $urandom_range(2) - 1;
						if (d > DIST_MAX)
							d = DIST_MAX;
					end else begin
						d = $urandom_range(DIST_MAX);
					end
					p.edge_dist = DIST_W'(d);
					p.near_px   = rgb_t'(24'($urandom));
					p.far_px    = rgb_t'(24'($urandom));
					send_pair(p);
				end
			end
		end
	endtask

	initial begin
		regs_shadow              = '0;
		regs_shadow.image_width  = 1;
		regs_shadow.image_height = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_passthrough();
		test_band_edges();
		test_zero_band();
		test_register_limits();
		test_random_traffic();
		drain_results();
		// catch any stray result after the last owed one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[mirror_edge_blend_rgb] OK");
		else
			$display("[mirror_edge_blend_rgb] ERROR");
		$finish;
	end

endmodule

/* mirror_edge_blend_rgb.f */
+incdir+rtl
rtl/meb_pkg.sv
rtl/meb_div.sv
rtl/meb_cal.sv
rtl/meb_blend.sv
rtl/mirror_edge_blend_rgb.sv
bench/tb_mirror_edge_blend_rgb.sv
